[rtl/tom_pkg.sv]
`default_nettype none

package tom_pkg;

    localparam int MAG_W  = 13;
    localparam int DIVS_W = 8;

    localparam logic [MAG_W-1:0] MAG_CLAMP    = 13'd4096;
    localparam logic [MAG_W-1:0] ACTIVE_LEVEL = 13'd200;
    localparam logic [3:0]       COUNT_MAX    = 4'd15;
    localparam logic [15:0]      CMP_RESET    = 16'd1000;
    localparam logic [15:0]      SAT_MAX      = 16'hFFFF;

    localparam logic [11:0] CENTER_RESET   = 12'd1024;
    localparam logic [3:0]  GAIN_RESET     = 4'd2;
    localparam logic [7:0]  DIVISOR_RESET  = 8'd80;
    localparam logic [15:0] OFFSET_RESET   = 16'd1500;
    localparam logic [3:0]  OVR_TICK_RESET = 4'd5;
    localparam logic [3:0]  RES_TICK_RESET = 4'd10;

    typedef enum logic [1:0] {
        REQ_EDGE   = 2'd0,
        REQ_TICK   = 2'd1,
        REQ_RESUME = 2'd2
    } req_t;

    typedef enum logic [2:0] {
        CFG_CENTER    = 3'd0,
        CFG_GAIN      = 3'd1,
        CFG_DIVISOR   = 3'd2,
        CFG_OFFSET    = 3'd3,
        CFG_OVR_TICKS = 3'd4,
        CFG_RES_TICKS = 3'd5
    } cfg_idx_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_DIV  = 1'b1
    } state_t;

    typedef struct packed {
        logic              start;
        logic [MAG_W-1:0]  dividend;
        logic [DIVS_W-1:0] divisor;
    } div_req_t;

    function automatic logic [3:0] count_up(input logic [3:0] c);
        return (c >= COUNT_MAX) ? COUNT_MAX : c + 4'd1;
    endfunction

endpackage

`default_nettype wire

[rtl/throttle_override_mux.sv]
// throttle_override_mux
// Slave stream s_*: one beat per request. s_tuser carries the request kind
// (edge capture, control tick, resume auto). Master stream m_*: exactly one
// result beat per request, reporting the compare value, mode, last
// measured width and last throttle magnitude after that request.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high and writes take effect at the next edge. Writes are to be
// issued only while no request is in flight; the block does not enforce this.
// Edge, resume and unused requests need no divide: the result beat is
// valid the cycle after acceptance. A control tick runs the magnitude
// through a restoring divider that retires one quotient bit per cycle, and
// its result beat is valid once the divider reports done; the block takes
// no new request while the tick is in the divider.
// s_tready is low while a tick is in the divider and while an undelivered
// result beat is stalled by m_tready; the result holds until taken.
// Reset (aresetn low, synchronous) restores the default configuration,
// automatic mode, compare value 1000 and clears all counters and captures.
`default_nettype none

module throttle_override_mux (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [0] pin_level, [16:1] capture_time, [28:17] analog_sample
    input  wire logic [31:0] s_tdata,
    // [1:0] req_type
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [15:0] pulse_command, [16] auto_active, [32:17] measured_width,
    // [45:33] throttle_magnitude
    output logic [47:0]      m_tdata,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    import tom_pkg::*;

    logic [11:0] center_reg;
    logic [3:0]  gain_reg;
    logic [7:0]  divisor_reg;
    logic [15:0] offset_reg;
    logic [3:0]  ovr_ticks_reg;
    logic [3:0]  res_ticks_reg;

    state_t           state_reg, state_next;
    logic [15:0]      rise_reg, rise_next;
    logic [15:0]      width_reg, width_next;
    logic             auto_reg, auto_next;
    logic [3:0]       ovr_cnt_reg, ovr_cnt_next;
    logic [3:0]       res_cnt_reg, res_cnt_next;
    logic [15:0]      cmp_reg, cmp_next;
    logic [MAG_W-1:0] mag_reg, mag_next;
    logic             m_valid_reg, m_valid_next;

    logic              pin_level;
    logic [15:0]       capture_time;
    logic [11:0]       analog_sample;
    logic              accept;
    logic signed [12:0] centered;
    logic signed [16:0] prod;
    logic [16:0]       prod_abs;
    logic [MAG_W-1:0]  mag_in;
    logic [7:0]        div_eff;
    div_req_t          div_req;
    logic              div_done;
    logic [MAG_W-1:0]  quotient;
    logic [16:0]       times_ten;
    logic [17:0]       manual_sum;
    logic [15:0]       manual;
    logic [3:0]        cnt_up;

    assign pin_level     = s_tdata[0];
    assign capture_time  = s_tdata[16:1];
    assign analog_sample = s_tdata[28:17];

    assign s_tready  = (state_reg == ST_IDLE) && (!m_valid_reg || m_tready);
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_reg    <= CENTER_RESET;
            gain_reg      <= GAIN_RESET;
            divisor_reg   <= DIVISOR_RESET;
            offset_reg    <= OFFSET_RESET;
            ovr_ticks_reg <= OVR_TICK_RESET;
            res_ticks_reg <= RES_TICK_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_CENTER:    center_reg    <= cfg_data[11:0];
                CFG_GAIN:      gain_reg      <= cfg_data[3:0];
                CFG_DIVISOR:   divisor_reg   <= cfg_data[7:0];
                CFG_OFFSET:    offset_reg    <= cfg_data;
                CFG_OVR_TICKS: ovr_ticks_reg <= cfg_data[3:0];
                CFG_RES_TICKS: res_ticks_reg <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        centered = $signed({1'b0, analog_sample}) - $signed({1'b0, center_reg});
        prod     = $signed({{4{centered[12]}}, centered}) * $signed({13'd0, gain_reg});
        prod_abs = prod[16] ? 17'(-prod) : 17'(prod);
        mag_in   = (prod_abs > 17'(MAG_CLAMP)) ? MAG_CLAMP : prod_abs[MAG_W-1:0];
        div_eff  = (divisor_reg == 8'd0) ? 8'd1 : divisor_reg;
    end

    assign div_req.start    = accept && (s_tuser == REQ_TICK);
    assign div_req.dividend = mag_in;
    assign div_req.divisor  = div_eff;

    tom_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (div_req),
        .done     (div_done),
        .quotient (quotient)
    );

    always_comb begin
        times_ten  = {1'b0, quotient, 3'b000} + {3'b000, quotient, 1'b0};
        manual_sum = {1'b0, times_ten} + {2'b00, offset_reg};
        manual     = (manual_sum > 18'(SAT_MAX)) ? SAT_MAX : manual_sum[15:0];
        cnt_up     = auto_reg ? count_up(ovr_cnt_reg) : count_up(res_cnt_reg);
    end

    always_comb begin
        state_next   = state_reg;
        rise_next    = rise_reg;
        width_next   = width_reg;
        auto_next    = auto_reg;
        ovr_cnt_next = ovr_cnt_reg;
        res_cnt_next = res_cnt_reg;
        cmp_next     = cmp_reg;
        mag_next     = mag_reg;
        m_valid_next = m_valid_reg && !m_tready;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (s_tuser)
                        REQ_EDGE: begin
                            if (pin_level) begin
                                rise_next = capture_time;
                            end else begin
                                width_next = capture_time - rise_reg;
                            end
                            m_valid_next = 1'b1;
                        end
                        REQ_TICK: begin
                            mag_next   = mag_in;
                            state_next = ST_DIV;
                        end
                        REQ_RESUME: begin
                            auto_next    = 1'b1;
                            ovr_cnt_next = 4'd0;
                            m_valid_next = 1'b1;
                        end
                        default: begin
                            m_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    if (auto_reg) begin
                        cmp_next = width_reg;
                        if (mag_reg > ACTIVE_LEVEL) begin
                            ovr_cnt_next = cnt_up;
                            if (cnt_up > ovr_ticks_reg) begin
                                auto_next    = 1'b0;
                                ovr_cnt_next = ovr_ticks_reg;
                            end
                        end else begin
                            ovr_cnt_next = 4'd0;
                        end
                    end else begin
                        cmp_next     = manual;
                        res_cnt_next = (mag_reg <= ACTIVE_LEVEL) ? cnt_up : 4'd0;
                        if (res_cnt_next > res_ticks_reg) begin
                            auto_next    = 1'b1;
                            res_cnt_next = 4'd0;
                        end
                    end
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            rise_reg    <= '0;
            width_reg   <= '0;
            auto_reg    <= 1'b1;
            ovr_cnt_reg <= '0;
            res_cnt_reg <= '0;
            cmp_reg     <= CMP_RESET;
            mag_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rise_reg    <= rise_next;
            width_reg   <= width_next;
            auto_reg    <= auto_next;
            ovr_cnt_reg <= ovr_cnt_next;
            res_cnt_reg <= res_cnt_next;
            cmp_reg     <= cmp_next;
            mag_reg     <= mag_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, mag_reg, width_reg, auto_reg, cmp_reg};

    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_valid_reg && !m_tready))
        else $error("input taken while result stalled");

    a_div_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> !m_valid_reg)
        else $error("result pending during divide");

    a_tick_divides: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_tuser == REQ_TICK) |=> (state_reg == ST_DIV))
        else $error("tick did not start divide");

    a_fast_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_tuser != REQ_TICK) |=> m_valid_reg)
        else $error("single-cycle request gave no result");

endmodule

`default_nettype wire

[rtl/tom_div.sv]
`default_nettype none

module tom_div (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire tom_pkg::div_req_t         req,
    output logic                           done,
    output logic [tom_pkg::MAG_W-1:0]      quotient
);
    import tom_pkg::*;

    localparam int CNT_W = $clog2(MAG_W + 1);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(MAG_W);

    logic [MAG_W-1:0]  dq_reg, dq_next;
    logic [DIVS_W-1:0] rem_reg, rem_next;
    logic [DIVS_W-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              run_reg, run_next;
    logic [DIVS_W:0]   trial;
    logic [DIVS_W:0]   diff;
    logic              fits;

    always_comb begin
        trial    = {rem_reg, dq_reg[MAG_W-1]};
        diff     = trial - {1'b0, dvs_reg};
        fits     = trial >= {1'b0, dvs_reg};
        dq_next  = dq_reg;
        rem_next = rem_reg;
        dvs_next = dvs_reg;
        cnt_next = cnt_reg;
        run_next = run_reg;
        if (req.start) begin
            dq_next  = req.dividend;
            rem_next = '0;
            dvs_next = req.divisor;
            cnt_next = '0;
            run_next = 1'b1;
        end else if (run_reg && cnt_reg != LAST) begin
            dq_next  = {dq_reg[MAG_W-2:0], fits};
            rem_next = fits ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];
            cnt_next = cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            run_reg <= run_next;
            cnt_reg <= cnt_next;
        end
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = run_reg && (cnt_reg == LAST) && !req.start;
    assign quotient = dq_reg;

endmodule

`default_nettype wire
